// File: src/vidb_pkg.sv
// Package with shared types and constants of the vehicle input debounce bank.
package vidb_pkg;

  localparam int NUM_CH     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CH_HIBEAM = 0;
  localparam int CH_LOBEAM = 1;
  localparam int CH_IGN    = 2;
  localparam int CH_HORN   = 3;

  // Channels ic1, ckey and learnkey always expect a low pin.
  localparam logic [NUM_CH-1:0] FIXED_LOW_MASK = 12'hD00;

  localparam logic [7:0] HORN_MIN_PHASE  = 8'd5;
  localparam logic [7:0] HORN_MIN_PULSES = 8'd5;
  localparam logic [7:0] PULSE_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2
  } vidb_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLARITY   = 3'd0,
    REG_LAMP_EN    = 3'd1,
    REG_DEB_COUNT  = 3'd2,
    REG_HORN_HOLD  = 3'd3,
    REG_BEAM_DELAY = 3'd4
  } vidb_reg_t;

  // Per-channel update request toward a run-counter debouncer.
  typedef struct packed {
    logic upd;
    logic pin;
    logic expect_lvl;
  } vidb_chan_req_t;

  // Control toward the horn channel.
  typedef struct packed {
    logic sample;
    logic tick;
    logic learn;
    logic pin;
    logic expect_lvl;
  } vidb_horn_req_t;

endpackage

// File: src/vidb_if.sv
// Request and result channel interfaces of the vehicle input debounce bank.
interface vidb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        learn_mode;
  logic [11:0] raw_pins;

  modport source (output valid, output command, output learn_mode, output raw_pins,
                  input ready);
  modport sink   (input valid, input command, input learn_mode, input raw_pins,
                  output ready);
endinterface

interface vidb_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] levels;
  logic [11:0] change_flags;

  modport source (output valid, output levels, output change_flags, input ready);
  modport sink   (input valid, input levels, input change_flags, output ready);
endinterface

// File: src/vidb_chan.sv
// Run-counter debouncer for one generic switch channel.
module vidb_chan #(
  parameter int RUN_WIDTH = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vidb_pkg::vidb_chan_req_t req,
  input  logic [7:0]              debounce_count,
  input  logic                    level_cur,
  output logic                    level_nxt
);
  import vidb_pkg::*;

  localparam int CW = (RUN_WIDTH > 8) ? RUN_WIDTH : 8;

  logic [RUN_WIDTH-1:0] match_run_r, match_run_nxt;
  logic [RUN_WIDTH-1:0] mism_run_r, mism_run_nxt;
  logic                 hit;
  logic [CW-1:0]        thresh;

  assign hit    = (req.pin == req.expect_lvl);
  assign thresh = CW'(debounce_count);

  always_comb begin
    level_nxt     = level_cur;
    match_run_nxt = match_run_r;
    mism_run_nxt  = mism_run_r;
    if (req.upd) begin
      if (hit) begin
        if (CW'(match_run_r) >= thresh) level_nxt = 1'b1;
        if (match_run_r != '1) match_run_nxt = match_run_r + RUN_WIDTH'(1);
        mism_run_nxt = '0;
      end else begin
        if (CW'(mism_run_r) >= thresh) level_nxt = 1'b0;
        if (mism_run_r != '1) mism_run_nxt = mism_run_r + RUN_WIDTH'(1);
        match_run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_run_r <= '0;
      mism_run_r  <= '0;
    end else begin
      match_run_r <= match_run_nxt;
      mism_run_r  <= mism_run_nxt;
    end
  end

endmodule

// File: src/vidb_horn.sv
// Horn channel: phase timers, pulse-train counting and level settling.
module vidb_horn #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vidb_pkg::vidb_horn_req_t req,
  input  logic                    pol_horn,
  input  logic [15:0]             hold_ticks,
  input  logic                    level_cur,
  output logic                    level_nxt
);
  import vidb_pkg::*;

  localparam int HW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [TIMER_WIDTH-1:0] tmr_r   [2];
  logic [TIMER_WIDTH-1:0] tmr_nxt [2];
  logic [1:0]             flag_r, flag_nxt;
  logic [7:0]             cnt_r   [2];
  logic [7:0]             cnt_nxt [2];
  logic                   mine;
  logic [TIMER_WIDTH-1:0] other_tmr;

  // Phase index: 0 while the pin matches, 1 while it differs.
  assign mine      = (req.pin != req.expect_lvl);
  assign other_tmr = mine ? tmr_r[0] : tmr_r[1];

  always_comb begin
    level_nxt = level_cur;
    flag_nxt  = flag_r;
    for (int k = 0; k < 2; k++) begin
      tmr_nxt[k] = tmr_r[k];
      cnt_nxt[k] = cnt_r[k];
    end
    if (req.sample) begin
      for (int k = 0; k < 2; k++) begin
        if (mine == k[0]) begin
          // End of this phase: count it if long enough, stop its timer.
          if (tmr_r[k] >= TIMER_WIDTH'(HORN_MIN_PHASE) && cnt_r[k] != PULSE_MAX)
            cnt_nxt[k] = cnt_r[k] + 8'd1;
          tmr_nxt[k]  = '0;
          flag_nxt[k] = 1'b0;
        end else begin
          flag_nxt[k] = 1'b1;
        end
      end
      if (HW'(other_tmr) >= HW'(hold_ticks)) begin
        cnt_nxt[0] = '0;
        cnt_nxt[1] = '0;
        level_nxt  = ~mine;
      end
      if (cnt_nxt[0] > HORN_MIN_PULSES && cnt_nxt[1] > HORN_MIN_PULSES) begin
        cnt_nxt[0] = '0;
        cnt_nxt[1] = '0;
        level_nxt  = req.learn ? 1'b1 : ~pol_horn;
      end
    end else if (req.tick) begin
      for (int k = 0; k < 2; k++) begin
        if (flag_r[k] && tmr_r[k] != '1) tmr_nxt[k] = tmr_r[k] + TIMER_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
      for (int k = 0; k < 2; k++) begin
        tmr_r[k] <= '0;
        cnt_r[k] <= '0;
      end
    end else begin
      flag_r <= flag_nxt;
      for (int k = 0; k < 2; k++) begin
        tmr_r[k] <= tmr_nxt[k];
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

endmodule

// File: src/vehicle_input_debounce_bank.sv
// Top level of the twelve-channel vehicle switch debounce bank.
//
//  channel   port      direction  payload
//  request   in_req    sink       command[1:0], learn_mode, raw_pins[11:0]
//  result    out_res   source     levels[11:0], change_flags[11:0]
//  config    cfg_*     write      cfg_index[2:0], cfg_wdata[15:0] on cfg_we
//
// Each request passes through the input register and then the result register;
// one request per cycle is sustained while out_res takes each result, with a
// single combinational update pass between those two registers.
// Reset (rst_n low, synchronous) clears valid flags and channel state and loads register defaults.
// A stalled result holds in the output register; the input register still
// accepts when the output register will empty in the same cycle.
module vehicle_input_debounce_bank #(
  parameter int TIMER_WIDTH = 16,
  parameter int RUN_WIDTH   = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  vidb_in_if.sink                             in_req,
  vidb_out_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [vidb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vidb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vidb_pkg::*;

  localparam int TW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // Configuration registers.
  logic [NUM_CH-1:0] pol_r;
  logic              lamp_en_r;
  logic [7:0]        deb_count_r;
  logic [15:0]       horn_hold_r;
  logic [15:0]       beam_delay_r;

  // Input register.
  logic              s1_valid_r;
  logic [1:0]        s1_cmd_r;
  logic              s1_learn_r;
  logic [NUM_CH-1:0] s1_pins_r;

  // Channel state and result register.
  logic [NUM_CH-1:0]      level_r, level_nxt;
  logic [NUM_CH-1:0]      change_r, change_nxt;
  logic [TIMER_WIDTH-1:0] beam_timer_r, beam_timer_nxt;
  logic                   out_valid_r;
  logic [NUM_CH-1:0]      out_levels_r;
  logic [NUM_CH-1:0]      out_change_r;

  logic              s1_adv;
  logic              do_sample, do_tick, do_clear;
  logic [NUM_CH-1:0] expect_lvl;
  logic              beams_on;
  vidb_horn_req_t    horn_req;

  // Advance the input register whenever the result register is free or drains.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;

  assign do_sample = s1_adv && (s1_cmd_r == CMD_SAMPLE);
  assign do_tick   = s1_adv && (s1_cmd_r == CMD_TICK);
  assign do_clear  = s1_adv && (s1_cmd_r == CMD_CLEAR);

  // Learn mode expects every pin low; some channels always do.
  assign expect_lvl = s1_learn_r ? '0 : (pol_r & ~FIXED_LOW_MASK);

  // Gate the beams on lamp enable; in normal mode also on ignition pin and
  // the beam delay, judged on the timer as it stood before this request.
  assign beams_on = lamp_en_r &&
                    (s1_learn_r || (!s1_pins_r[CH_IGN] &&
                                    (TW'(beam_timer_r) > TW'(beam_delay_r))));

  genvar ch;
  generate
    for (ch = 0; ch < NUM_CH; ch++) begin : g_ch
      if (ch != CH_HORN) begin : g_deb
        vidb_chan_req_t req;
        always_comb begin
          req.pin        = s1_pins_r[ch];
          req.expect_lvl = expect_lvl[ch];
          if (ch == CH_HIBEAM || ch == CH_LOBEAM) begin
            req.upd = do_sample && beams_on;
          end else if (ch == CH_IGN) begin
            req.upd = do_sample && !s1_learn_r;
          end else begin
            req.upd = do_sample;
          end
        end
        vidb_chan #(.RUN_WIDTH(RUN_WIDTH)) u_chan (
          .clk            (clk),
          .rst_n          (rst_n),
          .req            (req),
          .debounce_count (deb_count_r),
          .level_cur      (level_r[ch]),
          .level_nxt      (level_nxt[ch])
        );
      end
    end
  endgenerate

  assign horn_req.sample     = do_sample;
  assign horn_req.tick       = do_tick;
  assign horn_req.learn      = s1_learn_r;
  assign horn_req.pin        = s1_pins_r[CH_HORN];
  assign horn_req.expect_lvl = expect_lvl[CH_HORN];

  vidb_horn #(.TIMER_WIDTH(TIMER_WIDTH)) u_horn (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (horn_req),
    .pol_horn   (pol_r[CH_HORN]),
    .hold_ticks (horn_hold_r),
    .level_cur  (level_r[CH_HORN]),
    .level_nxt  (level_nxt[CH_HORN])
  );

  // Latch a change flag on any level edge; drop all flags on a clear request.
  assign change_nxt = do_clear ? '0 : (change_r | (level_r ^ level_nxt));

  always_comb begin
    beam_timer_nxt = beam_timer_r;
    if (do_tick && beam_timer_r != '1) begin
      beam_timer_nxt = beam_timer_r + TIMER_WIDTH'(1);
    end else if (do_sample && !s1_learn_r && !level_nxt[CH_IGN]) begin
      // Hold the beam timer at zero while ignition is off.
      beam_timer_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r        <= '0;
      lamp_en_r    <= 1'b1;
      deb_count_r  <= 8'd10;
      horn_hold_r  <= 16'd2000;
      beam_delay_r <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLARITY:   pol_r        <= cfg_wdata[NUM_CH-1:0];
        REG_LAMP_EN:    lamp_en_r    <= cfg_wdata[0];
        REG_DEB_COUNT:  deb_count_r  <= cfg_wdata[7:0];
        REG_HORN_HOLD:  horn_hold_r  <= cfg_wdata;
        REG_BEAM_DELAY: beam_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      level_r      <= '0;
      change_r     <= '0;
      beam_timer_r <= '0;
    end else begin
      if (in_req.ready) s1_valid_r <= in_req.valid;
      if (s1_adv) begin
        out_valid_r  <= 1'b1;
        level_r      <= level_nxt;
        change_r     <= change_nxt;
        beam_timer_r <= beam_timer_nxt;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      s1_cmd_r   <= in_req.command;
      s1_learn_r <= in_req.learn_mode;
      s1_pins_r  <= in_req.raw_pins;
    end
    if (s1_adv) begin
      out_levels_r <= level_nxt;
      out_change_r <= change_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.levels       = out_levels_r;
  assign out_res.change_flags = out_change_r;

endmodule
